// File: sv/tofp_pkg.sv
`timescale 1ns / 1ps
package tofp_pkg;

  localparam int unsigned DIV_BITS = 32;
  localparam logic [15:0] SPAD_UNDEF = 16'h8000;
  localparam logic [15:0] SAT16 = 16'hFFFF;
  localparam logic [10:0] RANGE_GAIN = 11'd2011;
  localparam logic [26:0] RANGE_ROUND = 27'h0400;

  localparam logic [3:0] ST_HWFAIL = 4'd0;
  localparam logic [3:0] ST_MINRANGE = 4'd1;
  localparam logic [3:0] ST_SYNC = 4'd2;
  localparam logic [3:0] ST_BOUNDS = 4'd3;
  localparam logic [3:0] ST_SIGNAL = 4'd4;
  localparam logic [3:0] ST_WRAP = 4'd5;
  localparam logic [3:0] ST_XTALK = 4'd6;
  localparam logic [3:0] ST_CLIPPED = 4'd7;
  localparam logic [3:0] ST_VALID = 4'd8;
  localparam logic [3:0] ST_NONE = 4'd9;

  localparam logic [0:0] REG_TARGET_RATE = 1'b0;

  typedef struct packed {
    logic [15:0] distance_mm;
    logic [3:0]  status_class;
    logic [15:0] peak_rate;
    logic [15:0] ambient_rate;
    logic [15:0] total;
    logic [15:0] spad_count;
    logic        spad_zero;
  } tofp_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } tofp_qctl_t;

endpackage

// File: sv/tof_ranging_result_postprocess.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in_       in_valid / in_stall    raw_status, raw_range, ambient_rate, peak_rate, spad_count
// out_      out_valid / out_stall  distance_mm, status_class, spads_select, peak/ambient out
// cfg       APB psel/penable       target_rate at byte address 0
// One word is accepted per cycle while in_stall is low and one result leaves per cycle when out_stall is low.
// An accepted word passes through the queue, two 32-stage dividers that
// resolve one quotient bit per stage, then the output register.
// Reset is synchronous on rst_n and restores target_rate to 0x0A00.
// A stalled output freezes the whole back pipeline; a two-word queue absorbs the input.
module tof_ranging_result_postprocess (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_raw_status,
  input  logic [15:0] in_raw_range,
  input  logic [15:0] in_ambient_rate,
  input  logic [15:0] in_peak_rate,
  input  logic [15:0] in_spad_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_distance_mm,
  output logic [3:0]  out_status_class,
  output logic [15:0] out_spads_select,
  output logic [15:0] out_peak_rate_out,
  output logic [15:0] out_ambient_rate_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tofp_pkg::*;

  logic [15:0] target_rate_r;
  tofp_item_t  front_item, head_item;
  tofp_qctl_t  qctl;
  logic        en;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET_RATE) ? {16'd0, target_rate_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_rate_r <= 16'h0A00;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TARGET_RATE)) begin
      target_rate_r <= pwdata[15:0];
    end
  end

  tofp_front u_front (
    .raw_status   (in_raw_status),
    .raw_range    (in_raw_range),
    .ambient_rate (in_ambient_rate),
    .peak_rate    (in_peak_rate),
    .spad_count   (in_spad_count),
    .item         (front_item)
  );

  assign en = !(out_valid && out_stall);

  tofp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_valid),
    .pop     (en),
    .wr_item (front_item),
    .rd_item (head_item),
    .ctl     (qctl)
  );

  assign in_stall = qctl.full;

  tofp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .src_valid        (!qctl.empty),
    .src_item         (head_item),
    .target_rate      (target_rate_r),
    .res_valid        (out_valid),
    .res_distance_mm  (out_distance_mm),
    .res_status_class (out_status_class),
    .res_spads_select (out_spads_select),
    .res_peak_rate    (out_peak_rate_out),
    .res_ambient_rate (out_ambient_rate_out)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && qctl.full) |-> !qctl.push)
    else $error("queue written while full");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    qctl.pop |-> !qctl.empty)
    else $error("queue read while empty");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status_class <= ST_NONE))
    else $error("status class out of range");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall && rst_n) |-> $stable(out_spads_select))
    else $error("result changed under stall");
`endif

endmodule

// File: sv/tofp_front.sv
`timescale 1ns / 1ps
module tofp_front (
  input  logic [7:0]          raw_status,
  input  logic [15:0]         raw_range,
  input  logic [15:0]         ambient_rate,
  input  logic [15:0]         peak_rate,
  input  logic [15:0]         spad_count,
  output tofp_pkg::tofp_item_t item
);
  import tofp_pkg::*;

  logic [26:0] scaled;
  logic [16:0] sum;
  logic [3:0]  cls;

  always_comb begin
    case (raw_status) inside
      8'd1, 8'd2, 8'd3, 8'd17: cls = ST_HWFAIL;
      8'd13: cls = ST_MINRANGE;
      8'd18: cls = ST_SYNC;
      8'd5: cls = ST_BOUNDS;
      8'd4, 8'd6: cls = ST_SIGNAL;
      8'd7: cls = ST_WRAP;
      8'd12: cls = ST_XTALK;
      8'd8: cls = ST_CLIPPED;
      8'd9: cls = ST_VALID;
      default: cls = ST_NONE;
    endcase
  end

  assign scaled = {11'd0, raw_range} * {16'd0, RANGE_GAIN} + RANGE_ROUND;
  assign sum = {1'b0, peak_rate} + {1'b0, ambient_rate};

  always_comb begin
    item.distance_mm = scaled[26:11];
    item.status_class = cls;
    item.peak_rate = peak_rate;
    item.ambient_rate = ambient_rate;
    item.total = sum[16] ? SAT16 : sum[15:0];
    item.spad_count = spad_count;
    item.spad_zero = (spad_count == 16'd0);
  end

endmodule

// File: sv/tofp_queue.sv
`timescale 1ns / 1ps
module tofp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 pop,
  input  tofp_pkg::tofp_item_t wr_item,
  output tofp_pkg::tofp_item_t rd_item,
  output tofp_pkg::tofp_qctl_t ctl
);
  import tofp_pkg::*;

  tofp_item_t mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign do_push = push && (cnt_r != 2'd2);
  assign do_pop = pop && (cnt_r != 2'd0);
  assign wp_nxt = do_push ? ~wp_r : wp_r;
  assign rp_nxt = do_pop ? ~rp_r : rp_r;
  assign cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  assign rd_item = mem_r[rp_r];
  assign ctl.push = do_push;
  assign ctl.pop = do_pop;
  assign ctl.full = (cnt_r == 2'd2);
  assign ctl.empty = (cnt_r == 2'd0);

endmodule

// File: sv/tofp_back.sv
`timescale 1ns / 1ps
module tofp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 src_valid,
  input  tofp_pkg::tofp_item_t src_item,
  input  logic [15:0]          target_rate,
  output logic                 res_valid,
  output logic [15:0]          res_distance_mm,
  output logic [3:0]           res_status_class,
  output logic [15:0]          res_spads_select,
  output logic [15:0]          res_peak_rate,
  output logic [15:0]          res_ambient_rate
);
  import tofp_pkg::*;

  logic                d1_v_r   [DIV_BITS];
  tofp_item_t          d1_it_r  [DIV_BITS];
  logic [15:0]         d1_rem_r [DIV_BITS];
  logic [DIV_BITS-1:0] d1_num_r [DIV_BITS];

  logic                d2_v_r   [DIV_BITS];
  tofp_item_t          d2_it_r  [DIV_BITS];
  logic [DIV_BITS-1:0] d2_den_r [DIV_BITS];
  logic [DIV_BITS-1:0] d2_rem_r [DIV_BITS];
  logic [DIV_BITS-1:0] d2_num_r [DIV_BITS];

  logic        res_valid_r;
  logic [15:0] res_range_r, res_spads_r, res_peak_r, res_amb_r;
  logic [3:0]  res_status_r;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_d1
    logic                v_i;
    tofp_item_t          it_i;
    logic [15:0]         rem_i;
    logic [DIV_BITS-1:0] num_i;
    logic [16:0]         sh;
    logic [16:0]         diff;
    logic                q;
    if (k == 0) begin : g_src
      assign v_i = src_valid;
      assign it_i = src_item;
      assign rem_i = 16'd0;
      assign num_i = {src_item.total, 16'd0};
    end else begin : g_prev
      assign v_i = d1_v_r[k-1];
      assign it_i = d1_it_r[k-1];
      assign rem_i = d1_rem_r[k-1];
      assign num_i = d1_num_r[k-1];
    end
    assign sh = {rem_i, num_i[DIV_BITS-1]};
    assign diff = sh - {1'b0, it_i.spad_count};
    assign q = (sh >= {1'b0, it_i.spad_count});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[k] <= 1'b0;
      end else if (en) begin
        d1_v_r[k] <= v_i;
      end
      if (en) begin
        d1_it_r[k] <= it_i;
        d1_rem_r[k] <= q ? diff[15:0] : sh[15:0];
        d1_num_r[k] <= {num_i[DIV_BITS-2:0], q};
      end
    end
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_d2
    logic                v_i;
    tofp_item_t          it_i;
    logic [DIV_BITS-1:0] den_i;
    logic [DIV_BITS-1:0] rem_i;
    logic [DIV_BITS-1:0] num_i;
    logic [DIV_BITS:0]   sh;
    logic [DIV_BITS:0]   diff;
    logic                q;
    if (k == 0) begin : g_src
      assign v_i = d1_v_r[DIV_BITS-1];
      assign it_i = d1_it_r[DIV_BITS-1];
      assign den_i = d1_num_r[DIV_BITS-1];
      assign rem_i = '0;
      assign num_i = {target_rate, 16'd0};
    end else begin : g_prev
      assign v_i = d2_v_r[k-1];
      assign it_i = d2_it_r[k-1];
      assign den_i = d2_den_r[k-1];
      assign rem_i = d2_rem_r[k-1];
      assign num_i = d2_num_r[k-1];
    end
    assign sh = {rem_i, num_i[DIV_BITS-1]};
    assign diff = sh - {1'b0, den_i};
    assign q = (sh >= {1'b0, den_i});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v_r[k] <= 1'b0;
      end else if (en) begin
        d2_v_r[k] <= v_i;
      end
      if (en) begin
        d2_it_r[k] <= it_i;
        d2_den_r[k] <= den_i;
        d2_rem_r[k] <= q ? diff[DIV_BITS-1:0] : sh[DIV_BITS-1:0];
        d2_num_r[k] <= {num_i[DIV_BITS-2:0], q};
      end
    end
  end

  tofp_item_t          fin_it;
  logic [DIV_BITS-1:0] fin_q;
  logic [15:0]         sel;

  assign fin_it = d2_it_r[DIV_BITS-1];
  assign fin_q = d2_num_r[DIV_BITS-1];

  always_comb begin
    if (fin_it.spad_zero || (d2_den_r[DIV_BITS-1] == '0)) begin
      sel = SPAD_UNDEF;
    end else if (fin_q[DIV_BITS-1:16] != '0) begin
      sel = SAT16;
    end else begin
      sel = fin_q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (en) begin
      res_valid_r <= d2_v_r[DIV_BITS-1];
    end
    if (en) begin
      res_range_r <= fin_it.distance_mm;
      res_status_r <= fin_it.status_class;
      res_spads_r <= sel;
      res_peak_r <= fin_it.peak_rate;
      res_amb_r <= fin_it.ambient_rate;
    end
  end

  assign res_valid = res_valid_r;
  assign res_distance_mm = res_range_r;
  assign res_status_class = res_status_r;
  assign res_spads_select = res_spads_r;
  assign res_peak_rate = res_peak_r;
  assign res_ambient_rate = res_amb_r;

endmodule
